// ===== hdl/xpd_pkg.sv =====
`timescale 1ns / 1ps

package xpd_pkg;

  // Table geometry. The table is split over a row of cells; entry e sits in
  // cell e mod NUM_CELLS at row e / NUM_CELLS of that cell's bank.
  localparam int MAX_COLOURS   = 256;
  localparam int MAX_KEY_CHARS = 4;
  localparam int NUM_CELLS     = 16;

  localparam int KEY_CHARS  = 4;
  localparam int KEY_W      = 8 * KEY_CHARS;
  localparam int COLOUR_W   = 24;
  localparam int TEXT_W     = 48;
  localparam int KLEN_W     = 3;
  localparam int ENTRY_W    = $clog2(MAX_COLOURS);
  localparam int COUNT_W    = $clog2(MAX_COLOURS + 1);
  localparam int CELL_W     = $clog2(NUM_CELLS);
  localparam int ROW_W      = ENTRY_W - CELL_W;
  localparam int BANK_DEPTH = 1 << ROW_W;

  localparam logic [KLEN_W-1:0] KEY_LENGTH_RESET = KLEN_W'(1);

  // Item selector codes.
  localparam logic [1:0] FUNC_DEFINE = 2'd0;
  localparam logic [1:0] FUNC_LOOKUP = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NONHEX = 2'd1;
  localparam logic [1:0] ST_MISS   = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  // ASCII codes used by the hex decoder.
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [7:0] HEX_TEN    = 8'd10;

  typedef enum logic [1:0] {
    TK_NONE,
    TK_WRITE,
    TK_LOOKUP
  } tok_kind_t;

  // What travels from cell to cell. A write carries the new entry; a lookup
  // carries one row number and collects the first hit of that row.
  typedef struct packed {
    tok_kind_t             kind;
    logic                  tag;
    logic [ROW_W-1:0]      row;
    logic [CELL_W-1:0]     pos;
    logic [CELL_W-1:0]     lane;
    logic                  found;
    logic [KEY_W-1:0]      key;
    logic [COLOUR_W-1:0]   colour;
  } token_t;

  // Search context shared by all cells while a lookup runs.
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [KEY_W-1:0]   mask;
    logic [COUNT_W-1:0] count;
  } search_t;

  function automatic logic hex_ok(input logic [7:0] c);
    return ((c >= CH_DIGIT_0) && (c <= CH_DIGIT_9)) ||
           ((c >= CH_LOWER_A) && (c <= CH_LOWER_F)) ||
           ((c >= CH_UPPER_A) && (c <= CH_UPPER_F));
  endfunction

  function automatic logic [7:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    v = c;
    if ((c >= CH_DIGIT_0) && (c <= CH_DIGIT_9)) begin
      v = c - CH_DIGIT_0;
    end else if ((c >= CH_LOWER_A) && (c <= CH_LOWER_F)) begin
      v = c - CH_LOWER_A + HEX_TEN;
    end else if ((c >= CH_UPPER_A) && (c <= CH_UPPER_F)) begin
      v = c - CH_UPPER_A + HEX_TEN;
    end
    return v;
  endfunction

  // One colour byte from a pair of characters, wrapping at eight bits.
  function automatic logic [7:0] hex_byte(input logic [7:0] hi, input logic [7:0] lo);
    logic [7:0] vh;
    logic [7:0] vl;
    vh = hex_val(hi);
    vl = hex_val(lo);
    return {vh[3:0], 4'h0} + vl;
  endfunction

  function automatic logic [KEY_W-1:0] key_mask(input logic [KLEN_W-1:0] klen);
    logic [KEY_W-1:0] m;
    int               n;
    m = '0;
    n = int'(klen);
    if (n > MAX_KEY_CHARS) begin
      n = MAX_KEY_CHARS;
    end
    if (n > KEY_CHARS) begin
      n = KEY_CHARS;
    end
    for (int j = 0; j < KEY_CHARS; j++) begin
      if (j < n) begin
        m[8*j +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

// ===== hdl/xpd_cell.sv =====
`timescale 1ns / 1ps

module xpd_cell import xpd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  token_t  tok_in,
  input  search_t srch,
  output token_t  tok_out
);

  logic [KEY_W-1:0]    bank_key    [BANK_DEPTH];
  logic [COLOUR_W-1:0] bank_colour [BANK_DEPTH];
  logic [KEY_W-1:0]    rd_key;
  logic [COLOUR_W-1:0] rd_colour;
  token_t              tok_mid;
  token_t              tok_next;
  logic                live;
  logic                hit;

  // A write lands in the cell whose position matches its lane.
  always_ff @(posedge clk) begin
    if ((tok_in.kind == TK_WRITE) && (tok_in.pos == tok_in.lane)) begin
      bank_key[tok_in.row]    <= tok_in.key;
      bank_colour[tok_in.row] <= tok_in.colour;
    end
    rd_key    <= bank_key[tok_in.row];
    rd_colour <= bank_colour[tok_in.row];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_mid.kind <= TK_NONE;
    end else begin
      tok_mid <= tok_in;
    end
  end

  assign live = COUNT_W'({tok_mid.row, tok_mid.pos}) < srch.count;
  assign hit  = (tok_mid.kind == TK_LOOKUP) && !tok_mid.found && live &&
                ((rd_key & srch.mask) == srch.key);

  always_comb begin
    tok_next     = tok_mid;
    tok_next.pos = tok_mid.pos + CELL_W'(1);
    if (hit) begin
      tok_next.found  = 1'b1;
      tok_next.colour = rd_colour;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.kind <= TK_NONE;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

// ===== hdl/xpd_ctrl.sv =====
`timescale 1ns / 1ps

module xpd_ctrl import xpd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [KLEN_W-1:0]  cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         func,
  input  logic [KEY_W-1:0]   key_chars,
  input  logic [TEXT_W-1:0]  hex_text,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         red,
  output logic [7:0]         green,
  output logic [7:0]         blue,
  output logic [1:0]         status,
  output token_t             issue,
  output search_t            srch,
  input  token_t             tok_ret
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t              state;
  state_t              state_next;
  logic [KLEN_W-1:0]   key_length;
  logic [COUNT_W-1:0]  count;
  logic [COUNT_W-1:0]  count_next;
  logic [COUNT_W-1:0]  count_m1;
  logic                tag;
  logic                tag_next;
  logic [KEY_W-1:0]    srch_key;
  logic [KEY_W-1:0]    srch_key_next;
  logic [ROW_W-1:0]    last_row;
  logic [ROW_W-1:0]    last_row_next;
  logic [ROW_W-1:0]    issue_row;
  logic [ROW_W-1:0]    issue_row_next;
  logic                issue_more;
  logic                issue_more_next;
  token_t              issue_next;
  logic                accept;
  logic [KEY_W-1:0]    mask;
  logic [KEY_W-1:0]    key_in;
  logic [COLOUR_W-1:0] colour_in;
  logic                nonhex;
  logic                out_load;
  logic [COLOUR_W-1:0] out_colour;
  logic [1:0]          out_status;

  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;
  assign mask     = key_mask(key_length);
  assign key_in   = key_chars & mask;
  assign count_m1 = count - COUNT_W'(1);

  assign srch.key   = srch_key;
  assign srch.mask  = mask;
  assign srch.count = count;

  // The first character pair becomes the red byte.
  always_comb begin
    colour_in = '0;
    nonhex    = 1'b0;
    for (int i = 0; i < 3; i++) begin
      colour_in[8*(2-i) +: 8] = hex_byte(hex_text[16*i +: 8], hex_text[16*i+8 +: 8]);
      if (!hex_ok(hex_text[16*i +: 8]) || !hex_ok(hex_text[16*i+8 +: 8])) begin
        nonhex = 1'b1;
      end
    end
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    tag_next        = tag;
    srch_key_next   = srch_key;
    last_row_next   = last_row;
    issue_row_next  = issue_row;
    issue_more_next = issue_more;
    issue_next      = issue;
    issue_next.kind = TK_NONE;
    out_load        = 1'b0;
    out_colour      = '0;
    out_status      = ST_OK;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (func)
            FUNC_DEFINE: begin
              out_load = 1'b1;
              if (count == COUNT_W'(MAX_COLOURS)) begin
                out_status = ST_FULL;
              end else begin
                out_colour        = colour_in;
                out_status        = nonhex ? ST_NONHEX : ST_OK;
                issue_next.kind   = TK_WRITE;
                issue_next.tag    = tag;
                issue_next.row    = count[ENTRY_W-1:CELL_W];
                issue_next.lane   = count[CELL_W-1:0];
                issue_next.pos    = '0;
                issue_next.found  = 1'b0;
                issue_next.key    = key_in;
                issue_next.colour = colour_in;
                count_next        = count + COUNT_W'(1);
              end
            end
            FUNC_LOOKUP: begin
              if (count == '0) begin
                out_load   = 1'b1;
                out_status = ST_MISS;
              end else begin
                state_next      = S_SCAN;
                tag_next        = !tag;
                srch_key_next   = key_in;
                last_row_next   = count_m1[ENTRY_W-1:CELL_W];
                issue_row_next  = '0;
                issue_more_next = 1'b1;
              end
            end
            FUNC_CLEAR: begin
              out_load   = 1'b1;
              count_next = '0;
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        // Rows go into the chain one a cycle and come back in the same order,
        // so the first returning hit is the first match in load order.
        if (issue_more) begin
          issue_next.kind   = TK_LOOKUP;
          issue_next.tag    = tag;
          issue_next.row    = issue_row;
          issue_next.lane   = '0;
          issue_next.pos    = '0;
          issue_next.found  = 1'b0;
          issue_next.key    = '0;
          issue_next.colour = '0;
          issue_row_next    = issue_row + ROW_W'(1);
          issue_more_next   = (issue_row != last_row);
        end
        // Rows left over from an earlier lookup carry the other tag.
        if ((tok_ret.kind == TK_LOOKUP) && (tok_ret.tag == tag)) begin
          if (tok_ret.found) begin
            out_load        = 1'b1;
            out_colour      = tok_ret.colour;
            out_status      = ST_OK;
            state_next      = S_IDLE;
            issue_more_next = 1'b0;
          end else if (tok_ret.row == last_row) begin
            out_load        = 1'b1;
            out_status      = ST_MISS;
            state_next      = S_IDLE;
            issue_more_next = 1'b0;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      key_length <= KEY_LENGTH_RESET;
      count      <= '0;
      tag        <= 1'b0;
      issue_more <= 1'b0;
      issue.kind <= TK_NONE;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      tag        <= tag_next;
      issue_more <= issue_more_next;
      issue      <= issue_next;
      if (cfg_we) begin
        key_length <= cfg_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    srch_key  <= srch_key_next;
    last_row  <= last_row_next;
    issue_row <= issue_row_next;
    if (out_load) begin
      red    <= out_colour[23:16];
      green  <= out_colour[15:8];
      blue   <= out_colour[7:0];
      status <= out_status;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(MAX_COLOURS))
    else $error("entry count beyond table size");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (accept && (func == FUNC_CLEAR)) |=> (count == '0))
    else $error("clear did not empty the table");

  a_define_appends: assert property (@(posedge clk) disable iff (rst)
    (accept && (func == FUNC_DEFINE) && (count != COUNT_W'(MAX_COLOURS)))
      |=> (count == $past(count) + COUNT_W'(1)))
    else $error("define did not append exactly one entry");

  a_empty_miss: assert property (@(posedge clk) disable iff (rst)
    (accept && (func == FUNC_LOOKUP) && (count == '0))
      |=> (out_valid && (status == ST_MISS)))
    else $error("lookup on empty table did not miss at once");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (issue.kind != TK_WRITE))
    else $error("write entered the chain during a lookup");

endmodule

// ===== hdl/xpm_palette_decoder.sv =====
`timescale 1ns / 1ps

// XPM palette decoder. Colour entries are held in a row of 16 cells, each
// with a bank of 16 entries; a lookup sends one token per loaded row of 16
// entries down the row, every cell passing it through its tok_mid and
// tok_out registers. The scan ends at the first returning hit, or misses
// when the last loaded row returns without one. Define, clear and a lookup
// on an empty table give a registered result in the cycle after the beat.
// The next beat is taken once the decoder is idle and its output register
// is not stalled. Only one lookup is in flight at a time, and a new beat
// can enter while an old result is held only if out_stall is low.
module xpm_palette_decoder import xpd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [KLEN_W-1:0]  cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         func,
  input  logic [KEY_W-1:0]   key_chars,
  input  logic [TEXT_W-1:0]  hex_text,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         red,
  output logic [7:0]         green,
  output logic [7:0]         blue,
  output logic [1:0]         status
);

  token_t  chain [NUM_CELLS+1];
  search_t srch;

  xpd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .key_chars (key_chars),
    .hex_text  (hex_text),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .status    (status),
    .issue     (chain[0]),
    .srch      (srch),
    .tok_ret   (chain[NUM_CELLS])
  );

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    xpd_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (chain[k]),
      .srch    (srch),
      .tok_out (chain[k+1])
    );
  end

endmodule
